### design/qhd_pkg.sv
// ----------------------------------------------------------------------------
// QAM hard-decision demapper package
// Widths, the per-stage token and shared constants of the decision pipeline.
// ----------------------------------------------------------------------------
package qhd_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int SAMPLE_FRAC_BITS = 8;
  localparam int MAG_W            = SAMPLE_W + 1;
  localparam int INT_W            = MAG_W - SAMPLE_FRAC_BITS;
  // Integer part, odd-level nudge and constellation offset, with a sign bit.
  localparam int V_W              = INT_W + 2;
  localparam int SYM_W            = 6;
  localparam int NUM_CELLS        = 3;

  typedef struct packed {
    logic signed [V_W-1:0] vi;
    logic signed [V_W-1:0] vq;
    logic [SYM_W-1:0]      sym;
    logic [1:0]            k;
    logic [1:0]            lvl;
  } qhd_tok_t;

endpackage

### design/qam_hard_decision_demapper.sv
// ----------------------------------------------------------------------------
// QAM hard-decision demapper
// Decides received Q7.8 I/Q samples to QPSK, QAM16 or QAM64 symbol bits.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_i_sample, in_q_sample) moves one
//   I/Q pair per transfer; the result channel (out_valid, out_stall,
//   out_symbol_bits) returns one symbol per pair, in order. I bits sit in the
//   upper half of the symbol and Q bits in the lower half.
//   cfg_bits_per_axis selects 1 (QPSK), 2 (QAM16) or 3 (QAM64) bits per axis;
//   write it through cfg_valid/cfg_ready only while no sample is in flight.
//   The pipeline is a front-end register, then a row of three decision
//   cells, one per level, each a register stage.
//   Throughput is one pair per cycle while out_stall is low; every stage takes
//   a new token whenever it is empty or its token moves on, so bubbles close up.
//   When the receiver stalls, the last cell holds its result and the stages
//   behind it fill; in_stall rises only once all four stages hold tokens.
//   Reset empties the pipeline and sets two bits per symbol (QPSK).
// ----------------------------------------------------------------------------
module qam_hard_decision_demapper
  import qhd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_i_sample,
  input  logic signed [SAMPLE_W-1:0] in_q_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [SYM_W-1:0]           out_symbol_bits,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_bits_per_axis
);

  logic [1:0] bpa_r;
  logic [1:0] bpa_nxt;
  logic       front_ready;

  logic     vld [NUM_CELLS+1];
  logic     rdy [NUM_CELLS+1];
  qhd_tok_t tok [NUM_CELLS+1];

  assign cfg_ready = 1'b1;
  assign bpa_nxt   = (cfg_valid && cfg_ready) ? cfg_bits_per_axis : bpa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpa_r <= 2'd1;
    end else begin
      bpa_r <= bpa_nxt;
    end
  end

  qhd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .i_sample  (in_i_sample),
    .q_sample  (in_q_sample),
    .k         (bpa_r),
    .out_valid (vld[0]),
    .out_tok   (tok[0]),
    .out_ready (rdy[0])
  );

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    qhd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[c]),
      .in_ready  (rdy[c]),
      .in_tok    (tok[c]),
      .out_valid (vld[c+1]),
      .out_tok   (tok[c+1]),
      .out_ready (rdy[c+1])
    );
  end

  assign rdy[NUM_CELLS]  = !out_stall;
  assign in_stall        = !front_ready;
  assign out_valid       = vld[NUM_CELLS];
  assign out_symbol_bits = tok[NUM_CELLS].sym;

  // Every level must have been decided by the time a token leaves the row.
  a_levels_done: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NUM_CELLS] |-> tok[NUM_CELLS].lvl == 2'd0)
    else $error("token left the cell row with undecided levels");

  // No symbol bit above the configured constellation size.
  a_sym_width: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NUM_CELLS] |-> (tok[NUM_CELLS].sym >> {tok[NUM_CELLS].k, 1'b0}) == '0)
    else $error("symbol bit set beyond the configured bits per axis");

  // The input is held off only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld[0] && vld[1] && vld[2] && vld[3] && out_stall))
    else $error("input stalled while the pipeline had room");

endmodule

### design/qhd_front.sv
// ----------------------------------------------------------------------------
// QAM demapper front end
// Truncates both components to the nearest odd integer level and removes the
// constellation offset, then registers the token for the decision cells.
// ----------------------------------------------------------------------------
module qhd_front
  import qhd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] i_sample,
  input  logic signed [SAMPLE_W-1:0] q_sample,
  input  logic [1:0]                 k,
  output logic                       out_valid,
  output qhd_tok_t                   out_tok,
  input  logic                       out_ready
);

  logic     valid_r;
  qhd_tok_t tok_r;
  qhd_tok_t tok_nxt;
  logic     load;

  function automatic logic signed [V_W-1:0] odd_level(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [1:0]                 kk
  );
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [INT_W-1:0]        n;
    logic signed [V_W-1:0]   v;
    logic signed [V_W-1:0]   offs;
    begin
      neg  = s[SAMPLE_W-1];
      mag  = neg ? MAG_W'(-{s[SAMPLE_W-1], s}) : MAG_W'({s[SAMPLE_W-1], s});
      n    = INT_W'(mag >> SAMPLE_FRAC_BITS);
      v    = neg ? -$signed(V_W'(n)) : $signed(V_W'(n));
      if (!v[0]) begin
        v = neg ? v - V_W'(1) : v + V_W'(1);
      end
      offs = $signed(V_W'(1) << kk);
      odd_level = v - offs;
    end
  endfunction

  always_comb begin
    tok_nxt     = '0;
    tok_nxt.vi  = odd_level(i_sample, k);
    tok_nxt.vq  = odd_level(q_sample, k);
    tok_nxt.k   = k;
    tok_nxt.lvl = k;
  end

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule

### design/qhd_cell.sv
// ----------------------------------------------------------------------------
// QAM demapper decision cell
// Decides one level for both axes, steps each value against its sign by the
// level step and hands the token on; a token with no levels left passes unchanged.
// ----------------------------------------------------------------------------
module qhd_cell
  import qhd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qhd_tok_t in_tok,
  output logic     out_valid,
  output qhd_tok_t out_tok,
  input  logic     out_ready
);

  logic                  valid_r;
  qhd_tok_t              tok_r;
  qhd_tok_t              tok_nxt;
  logic                  load;
  logic signed [V_W-1:0] step;
  logic                  i_hit;
  logic                  q_hit;
  logic [2:0]            i_idx;
  logic [2:0]            q_idx;

  always_comb begin
    step  = $signed(V_W'(1) << in_tok.lvl);
    i_hit = in_tok.vi[V_W-1] ? (in_tok.vi > -step) : (in_tok.vi < step);
    q_hit = in_tok.vq[V_W-1] ? (in_tok.vq > -step) : (in_tok.vq < step);
    i_idx = {1'b0, in_tok.lvl} + {1'b0, in_tok.k} - 3'd1;
    q_idx = {1'b0, in_tok.lvl} - 3'd1;
    tok_nxt = in_tok;
    if (in_tok.lvl != 2'd0) begin
      if (i_hit) begin
        tok_nxt.sym = tok_nxt.sym | (SYM_W'(1) << i_idx);
      end
      if (q_hit) begin
        tok_nxt.sym = tok_nxt.sym | (SYM_W'(1) << q_idx);
      end
      tok_nxt.vi  = in_tok.vi[V_W-1] ? in_tok.vi + step : in_tok.vi - step;
      tok_nxt.vq  = in_tok.vq[V_W-1] ? in_tok.vq + step : in_tok.vq - step;
      tok_nxt.lvl = in_tok.lvl - 2'd1;
    end
  end

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule
